### sv/esc_pkg.sv
// Shared types, constants and helper functions for the epoch-seconds to calendar converter.
// Used by esc_ctrl, esc_dp and epoch_seconds_to_calendar_unit.
package esc_pkg;

    localparam int unsigned EPOCH_W   = 32;
    localparam int unsigned ZONE_W    = 17;
    localparam int unsigned DAYS_W    = 16;      // up to 49710 days in a 32-bit count
    localparam int unsigned DIVISOR_W = 17;

    localparam logic signed [ZONE_W-1:0] ZONE_RESET = 17'sd28800;
    localparam logic [11:0]              BASE_YEAR  = 12'd1970;
    localparam logic [3:0]               MON_DEC    = 4'd11;
    localparam logic [31:0]              WEEK_BIAS  = 32'd4;   // 1970-01-01 was a Thursday

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_Q,
        ST_MUL_R,
        ST_SUB,
        ST_FIX,
        ST_SAVE_DAY,
        ST_SAVE_HOUR,
        ST_SAVE_MIN,
        ST_SAVE_WEEK,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_Q,
        OP_MUL_R,
        OP_SUB,
        OP_FIX,
        OP_SAVE_DAY,
        OP_SAVE_HOUR,
        OP_SAVE_MIN,
        OP_SAVE_WEEK,
        OP_YEAR,
        OP_MONTH,
        OP_OUT
    } t_dp_op;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN,
        DIV_WEEK
    } t_div_sel;

    typedef struct packed {
        t_dp_op   op;
        t_div_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic yr_done;
        logic mo_done;
    } t_dp_sts;

    typedef struct packed {
        logic [2:0]  weekday;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [11:0] year;
    } t_cal_result;

    function automatic logic [DIVISOR_W-1:0] div_const(input t_div_sel sel);
        logic [DIVISOR_W-1:0] d;
        case (sel)
            DIV_DAY:  d = 17'd86400;
            DIV_HOUR: d = 17'd3600;
            DIV_MIN:  d = 17'd60;
            DIV_WEEK: d = 17'd7;
            default:  d = 17'd7;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor); the quotient estimate from it is at most one short
    function automatic logic [EPOCH_W-1:0] recip_const(input t_div_sel sel);
        logic [EPOCH_W-1:0] m;
        case (sel)
            DIV_DAY:  m = 32'd49710;
            DIV_HOUR: m = 32'd1193046;
            DIV_MIN:  m = 32'd71582788;
            DIV_WEEK: m = 32'd613566756;
            default:  m = 32'd613566756;
        endcase
        return m;
    endfunction

    // A 32-bit count only reaches years 1970..2106, so 2100 is the only
    // century that needs the exception (2000 is divisible by 400).
    function automatic logic is_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != 12'd2100);
    endfunction

    function automatic logic [8:0] year_len(input logic [11:0] y);
        return is_leap(y) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] l;
        case (m)
            4'd0:    l = 5'd31;
            4'd1:    l = leap ? 5'd29 : 5'd28;
            4'd2:    l = 5'd31;
            4'd3:    l = 5'd30;
            4'd4:    l = 5'd31;
            4'd5:    l = 5'd30;
            4'd6:    l = 5'd31;
            4'd7:    l = 5'd31;
            4'd8:    l = 5'd30;
            4'd9:    l = 5'd31;
            4'd10:   l = 5'd30;
            4'd11:   l = 5'd31;
            default: l = 5'd31;
        endcase
        return l;
    endfunction

endpackage

### sv/esc_ctrl.sv
// Sequencer for the converter: steps the shared reciprocal divider, year and month loops.
// Depends on esc_pkg; drives esc_dp through t_dp_cmd and reads t_dp_sts.
module esc_ctrl
    import esc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state   r_state, n_state;
    t_div_sel r_sel, n_sel;
    logic     r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sel       <= DIV_DAY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd.op    = OP_NONE;
        o_cmd.sel   = r_sel;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_sel    = DIV_DAY;
                    n_state  = ST_MUL_Q;
                end
            end
            // each division: estimate, back-multiply, subtract, one correction
            ST_MUL_Q: begin
                o_cmd.op = OP_MUL_Q;
                n_state  = ST_MUL_R;
            end
            ST_MUL_R: begin
                o_cmd.op = OP_MUL_R;
                n_state  = ST_SUB;
            end
            ST_SUB: begin
                o_cmd.op = OP_SUB;
                n_state  = ST_FIX;
            end
            ST_FIX: begin
                o_cmd.op = OP_FIX;
                case (r_sel)
                    DIV_DAY:  n_state = ST_SAVE_DAY;
                    DIV_HOUR: n_state = ST_SAVE_HOUR;
                    DIV_MIN:  n_state = ST_SAVE_MIN;
                    DIV_WEEK: n_state = ST_SAVE_WEEK;
                    default:  n_state = ST_SAVE_WEEK;
                endcase
            end
            ST_SAVE_DAY: begin
                o_cmd.op = OP_SAVE_DAY;
                n_sel    = DIV_HOUR;
                n_state  = ST_MUL_Q;
            end
            ST_SAVE_HOUR: begin
                o_cmd.op = OP_SAVE_HOUR;
                n_sel    = DIV_MIN;
                n_state  = ST_MUL_Q;
            end
            ST_SAVE_MIN: begin
                o_cmd.op = OP_SAVE_MIN;
                n_sel    = DIV_WEEK;
                n_state  = ST_MUL_Q;
            end
            ST_SAVE_WEEK: begin
                o_cmd.op = OP_SAVE_WEEK;
                n_state  = ST_YEAR;
            end
            ST_YEAR: begin
                o_cmd.op = OP_YEAR;
                if (i_sts.yr_done) n_state = ST_MONTH;
            end
            ST_MONTH: begin
                o_cmd.op = OP_MONTH;
                if (i_sts.mo_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                // wait until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    // a pending word must never be overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT) |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result word dropped while stalled");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_LOAD) |-> (r_state == ST_IDLE && i_in_valid))
        else $error("load issued outside an input handshake");

endmodule

### sv/esc_dp.sv
// Datapath: zone offset register, shared reciprocal divider, year and month loops.
// Depends on esc_pkg; controlled by esc_ctrl through t_dp_cmd.
module esc_dp
    import esc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic signed [ZONE_W-1:0] i_cfg_wdata,
    input  logic [EPOCH_W-1:0]       i_epoch_seconds,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    output t_cal_result              o_result
);

    logic signed [ZONE_W-1:0] r_zone;
    logic [EPOCH_W-1:0]       r_w;        // dividend / running remainder
    logic [DAYS_W-1:0]        r_q;        // quotient
    logic [2*EPOCH_W-1:0]     r_prod;
    logic [DAYS_W-1:0]        r_days;
    logic [11:0]              r_year;
    logic [3:0]               r_mon;
    logic [4:0]               r_hour;
    logic [5:0]               r_minute;
    logic [5:0]               r_second;
    logic [2:0]               r_weekday;
    t_cal_result              r_result;

    logic [DIVISOR_W-1:0] dval;
    logic [EPOCH_W-1:0]   dval_ext;
    logic [DAYS_W-1:0]    q_est;
    logic [EPOCH_W-1:0]   mul_a;
    logic [EPOCH_W-1:0]   mul_b;
    logic [2*EPOCH_W-1:0] prod;
    logic [8:0]           ylen;
    logic [4:0]           mlen;

    always_comb begin
        dval     = div_const(i_cmd.sel);
        dval_ext = {{(EPOCH_W-DIVISOR_W){1'b0}}, dval};
        q_est    = r_prod[EPOCH_W +: DAYS_W];
        // one 32x32 multiplier: dividend times reciprocal, then quotient times divisor
        if (i_cmd.op == OP_MUL_Q) begin
            mul_a = r_w;
            mul_b = recip_const(i_cmd.sel);
        end else begin
            mul_a = {{(EPOCH_W-DAYS_W){1'b0}}, q_est};
            mul_b = dval_ext;
        end
        prod          = mul_a * mul_b;
        ylen          = year_len(r_year);
        mlen          = month_len(r_mon, is_leap(r_year));
        o_sts.yr_done = (r_days < {{(DAYS_W-9){1'b0}}, ylen});
        o_sts.mo_done = (r_days < {{(DAYS_W-5){1'b0}}, mlen}) || (r_mon == MON_DEC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= ZONE_RESET;
        end else if (i_cfg_we) begin
            r_zone <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_w    <= i_epoch_seconds + {{(EPOCH_W-ZONE_W){r_zone[ZONE_W-1]}}, r_zone};
                r_year <= BASE_YEAR;
                r_mon  <= '0;
            end
            OP_MUL_Q: begin
                r_prod <= prod;
            end
            OP_MUL_R: begin
                r_q    <= q_est;
                r_prod <= prod;
            end
            OP_SUB: begin
                r_w <= r_w - r_prod[EPOCH_W-1:0];
            end
            OP_FIX: begin
                if (r_w >= dval_ext) begin
                    r_w <= r_w - dval_ext;
                    r_q <= r_q + 1'b1;
                end
            end
            OP_SAVE_DAY: begin
                r_days <= r_q;
            end
            OP_SAVE_HOUR: begin
                r_hour <= r_q[4:0];
            end
            OP_SAVE_MIN: begin
                r_minute <= r_q[5:0];
                r_second <= r_w[5:0];
                r_w      <= {{(EPOCH_W-DAYS_W){1'b0}}, r_days} + WEEK_BIAS;
            end
            OP_SAVE_WEEK: begin
                r_weekday <= r_w[2:0];
            end
            OP_YEAR: begin
                if (!o_sts.yr_done) begin
                    r_days <= r_days - {{(DAYS_W-9){1'b0}}, ylen};
                    r_year <= r_year + 12'd1;
                end
            end
            OP_MONTH: begin
                if (!o_sts.mo_done) begin
                    r_days <= r_days - {{(DAYS_W-5){1'b0}}, mlen};
                    r_mon  <= r_mon + 4'd1;
                end
            end
            OP_OUT: begin
                r_result.year         <= r_year;
                r_result.month        <= r_mon + 4'd1;
                r_result.day_of_month <= r_days[4:0] + 5'd1;
                r_result.hour         <= r_hour;
                r_result.minute       <= r_minute;
                r_result.second       <= r_second;
                r_result.weekday      <= r_weekday;
            end
            default: begin
            end
        endcase
    end

    assign o_result = r_result;

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_MONTH) |-> (r_mon <= MON_DEC))
        else $error("month index past December");

    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_YEAR) |-> (r_year <= 12'd2106))
        else $error("year loop ran past 2106");

    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_OUT) |-> (r_days < {{(DAYS_W-5){1'b0}}, mlen}))
        else $error("day index exceeds month length");

    a_day_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SAVE_DAY) |-> (r_w < 32'd86400))
        else $error("second-of-day remainder not reduced");

    a_week_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SAVE_WEEK) |-> (r_w < 32'd7))
        else $error("weekday remainder not reduced");

endmodule

### sv/epoch_seconds_to_calendar_unit.sv
// Top level of the epoch-seconds to Gregorian calendar converter.
// Depends on esc_pkg, esc_ctrl and esc_dp.
//
// Converts a 32-bit seconds-since-1970 count, plus a signed 17-bit zone
// offset (reset 28800, written through i_cfg_we/i_cfg_wdata while no word is
// in flight; the user must keep to this, the block itself does not enforce
// it), into year, month, day, hour, minute, second and weekday. One word is
// worked on at a time. The four divisions (days, hours, minutes, weekday)
// share one 32x32 reciprocal multiplier, each as estimate, back-multiply,
// subtract, correct and save steps; the year loop then steps one year at a
// time from 1970, the month loop one month at a time, and the result
// register is loaded last. The input side is ready again as soon as the
// result is loaded, while that result waits on the output; the next word
// then holds before its result load until the waiting one is taken.
module epoch_seconds_to_calendar_unit
    import esc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic signed [ZONE_W-1:0] i_cfg_wdata,     // zone_offset_seconds
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [31:0]              s_axis_tdata,    // [31:0] epoch_seconds
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
    // [31:26] minute, [37:32] second, [40:38] weekday, [47:41] zero
    output logic [47:0]              m_axis_tdata
);

    t_dp_cmd     cmd;
    t_dp_sts     sts;
    t_cal_result result;

    esc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    esc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_epoch_seconds (s_axis_tdata),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_result        (result)
    );

    assign m_axis_tdata = {7'b0, result};

endmodule

### bench/epoch_seconds_to_calendar_unit_tb.sv
// Testbench for epoch_seconds_to_calendar_unit: drives timestamps over the stream
// input and checks each calendar word against a date predictor kept in the bench.
// Depends on esc_pkg for the zone width, its reset value and the result layout.
module epoch_seconds_to_calendar_unit_tb
    import esc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT     = 4_000_000;
    localparam int unsigned LONG_HOLD       = 3000;
    localparam int unsigned ITEMS_PER_PHASE = 215;
    localparam int unsigned SETTLE_CYCLES   = 300;    // above the worst item latency

    localparam logic signed [ZONE_W-1:0] ZONE_MIN = 17'h10000;    // -65536
    localparam logic signed [ZONE_W-1:0] ZONE_MAX = 17'h0FFFF;    //  65535

    localparam int unsigned SUN = 0;
    localparam int unsigned MON = 1;
    localparam int unsigned TUE = 2;
    localparam int unsigned THU = 4;
    localparam int unsigned SAT = 6;

    typedef enum int {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_TICK
    } t_rx_mode;

    // one row of the directed table; a want with year 0 means "use the predictor"
    typedef struct {
        bit                        set_zone;
        logic signed [ZONE_W-1:0]  zone;
        logic [31:0]               stamp;
        t_cal_result               want;
    } t_date_case;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic signed [ZONE_W-1:0] i_cfg_wdata = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [31:0]              s_axis_tdata = '0;    // [31:0] epoch_seconds
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
    // [31:26] minute, [37:32] second, [40:38] weekday, [47:41] zero
    logic [47:0]              m_axis_tdata;

    t_cal_result              expected_dates[$];
    logic signed [ZONE_W-1:0] zone_model = ZONE_RESET;
    int unsigned              fail_count = 0;
    int unsigned              cycle_count = 0;
    int unsigned              burst_left = 0;
    bit                       hold_req = 1'b0;

    epoch_seconds_to_calendar_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // local date and time of a timestamp under a given zone offset
    function automatic t_cal_result to_calendar(input logic [31:0] stamp,
                                                input logic signed [ZONE_W-1:0] zone);
        int unsigned mdays[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        logic [31:0] local_t;
        int unsigned day_count, sec_of_day, yr, mo, ylen, mlen;
        t_cal_result r;
        local_t    = stamp + {{(32-ZONE_W){zone[ZONE_W-1]}}, zone};
        day_count  = local_t / 32'd86400;
        sec_of_day = local_t % 32'd86400;
        r.weekday  = 3'((day_count + 4) % 7);
        yr = 1970;
        ylen = leap_year(yr) ? 366 : 365;
        while (day_count >= ylen) begin
            day_count -= ylen;
            yr++;
            ylen = leap_year(yr) ? 366 : 365;
        end
        if (leap_year(yr))
            mdays[1] = 29;
        mo = 0;
        while (mo < 11 && day_count >= mdays[mo]) begin
            day_count -= mdays[mo];
            mo++;
        end
        r.year         = 12'(yr);
        r.month        = 4'(mo + 1);
        r.day_of_month = 5'(day_count + 1);
        r.hour         = 5'(sec_of_day / 3600);
        r.minute       = 6'((sec_of_day % 3600) / 60);
        r.second       = 6'(sec_of_day % 60);
        return r;
    endfunction

    function automatic t_cal_result make_date(input int unsigned y, mo, d, h, mi, s, wd);
        t_cal_result r;
        r.year         = 12'(y);
        r.month        = 4'(mo);
        r.day_of_month = 5'(d);
        r.hour         = 5'(h);
        r.minute       = 6'(mi);
        r.second       = 6'(s);
        r.weekday      = 3'(wd);
        return r;
    endfunction

    function automatic t_date_case make_case(input int set_flag,
                                             input int zone_val,
                                             input logic [31:0] stamp,
                                             input t_cal_result want);
        t_date_case c;
        c.set_zone = (set_flag != 0);
        c.zone     = ZONE_W'(zone_val);
        c.stamp    = stamp;
        c.want     = want;
        return c;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // bursts of words with random gaps; valid stays high across back-to-back words
    task automatic send_stamp(input logic [31:0] stamp, input t_cal_result want);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tdata  <= stamp;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_dates.push_back(want);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_dates.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_zone(input logic signed [ZONE_W-1:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        zone_model = value;
    endtask

    // receiver: changing stall patterns, plus one long hold-off on request
    initial begin
        t_rx_mode    mode;
        int unsigned mode_left, hold_left, tick;
        bit          hold_done;
        mode = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        tick = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 400);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:  m_axis_tready <= 1'b1;
                    RX_LIGHT: m_axis_tready <= ($urandom_range(0, 9) < 7);
                    RX_HEAVY: m_axis_tready <= ($urandom_range(0, 9) < 2);
                    default:  m_axis_tready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // result checker and run limit
    always @(posedge i_clk) begin
        t_cal_result want, got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_dates.size() == 0) begin
                $error("result word %h with nothing expected", m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_dates.pop_front();
                got  = t_cal_result'(m_axis_tdata[40:0]);
                check_field("year", want.year, got.year);
                check_field("month", want.month, got.month);
                check_field("day_of_month", want.day_of_month, got.day_of_month);
                check_field("hour", want.hour, got.hour);
                check_field("minute", want.minute, got.minute);
                check_field("second", want.second, got.second);
                check_field("weekday", want.weekday, got.weekday);
                check_field("pad", 0, m_axis_tdata[47:41]);
            end
        end
    end

    initial begin
        t_date_case               date_cases[$];
        t_cal_result              want;
        logic [31:0]              stamp;
        logic signed [ZONE_W-1:0] zone;
        int unsigned              yr, y, day_total;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset zone is UTC+8 until the third row
        date_cases.push_back(make_case(0, 0, 32'd0, make_date(1970, 1, 1, 8, 0, 0, THU)));
        date_cases.push_back(make_case(0, 0, 32'hFFFF_FFFF,
                                       make_date(1970, 1, 1, 7, 59, 59, THU)));
        date_cases.push_back(make_case(1, 0, 32'd0, make_date(1970, 1, 1, 0, 0, 0, THU)));
        date_cases.push_back(make_case(0, 0, 32'hFFFF_FFFF,
                                       make_date(2106, 2, 7, 6, 28, 15, SUN)));
        date_cases.push_back(make_case(0, 0, 32'd951782400,
                                       make_date(2000, 2, 29, 0, 0, 0, TUE)));
        // leap-year Dec 31 must stay in its own year
        date_cases.push_back(make_case(0, 0, 32'd978220800,
                                       make_date(2000, 12, 31, 0, 0, 0, SUN)));
        date_cases.push_back(make_case(0, 0, 32'd978307199,
                                       make_date(2000, 12, 31, 23, 59, 59, SUN)));
        date_cases.push_back(make_case(0, 0, 32'd978307200,
                                       make_date(2001, 1, 1, 0, 0, 0, MON)));
        // 2100 is not a leap year
        date_cases.push_back(make_case(0, 0, 32'd4107542399,
                                       make_date(2100, 2, 28, 23, 59, 59, SUN)));
        date_cases.push_back(make_case(0, 0, 32'd4107542400,
                                       make_date(2100, 3, 1, 0, 0, 0, MON)));
        date_cases.push_back(make_case(0, 0, 32'd94608000, '0));
        date_cases.push_back(make_case(0, 0, 32'hAAAA_AAAA, '0));
        date_cases.push_back(make_case(0, 0, 32'h5555_5555, '0));
        date_cases.push_back(make_case(0, 0, 32'h8000_0000, '0));
        // negative local time wraps to the top of the range
        date_cases.push_back(make_case(1, -17'sd1, 32'd0,
                                       make_date(2106, 2, 7, 6, 28, 15, SUN)));
        date_cases.push_back(make_case(0, 0, 32'd1, make_date(1970, 1, 1, 0, 0, 0, THU)));
        // sum past 2^32-1 wraps near 1970
        date_cases.push_back(make_case(1, ZONE_MAX, 32'hFFFF_FFFF,
                                       make_date(1970, 1, 1, 18, 12, 14, THU)));
        date_cases.push_back(make_case(0, 0, 32'd0, make_date(1970, 1, 1, 18, 12, 15, THU)));
        date_cases.push_back(make_case(1, ZONE_MIN, 32'd0,
                                       make_date(2106, 2, 6, 12, 16, 0, SAT)));
        date_cases.push_back(make_case(0, 0, 32'd65536, make_date(1970, 1, 1, 0, 0, 0, THU)));
        date_cases.push_back(make_case(1, -17'sd43200, 32'd978307200, '0));
        date_cases.push_back(make_case(1, 17'sd50400, 32'd978220800, '0));

        foreach (date_cases[i]) begin
            if (date_cases[i].set_zone) begin
                drain();
                write_zone(date_cases[i].zone);
            end
            want = (date_cases[i].want.year != 0) ? date_cases[i].want
                                                   : to_calendar(date_cases[i].stamp, zone_model);
            send_stamp(date_cases[i].stamp, want);
        end

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0:       zone = ZONE_RESET;
                1:       zone = -17'sd43200;
                2:       zone = 17'sd50400;
                3:       zone = ZONE_MIN;
                4:       zone = ZONE_MAX;
                5:       zone = '0;
                default: zone = ZONE_W'($urandom_range(0, 32'h1FFFF));
            endcase
            drain();
            write_zone(zone);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 1 && n == 60)
                    hold_req <= 1'b1;
                if (phase == 4 && n == 100)
                    drain();
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: stamp = $urandom;
                    5:             stamp = $urandom_range(0, 200000);
                    6:             stamp = 32'hFFFF_FFFF - $urandom_range(0, 200000);
                    default: begin
                        // local time within a day of a new year
                        yr = $urandom_range(1971, 2106);
                        day_total = 0;
                        for (y = 1970; y < yr; y++)
                            day_total += leap_year(y) ? 366 : 365;
                        stamp = day_total * 32'd86400 + $urandom_range(0, 172799) - 32'd86400
                              - {{(32-ZONE_W){zone_model[ZONE_W-1]}}, zone_model};
                    end
                endcase
                send_stamp(stamp, to_calendar(stamp, zone_model));
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_dates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
